// ----- rtl/core/opstk_pkg.sv -----
package opstk_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 64;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int DEP_W  = 7;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // what one operation does to the store and pointer
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [PTR_W-1:0] ptr_nxt;
    logic             push;
    logic             read_top;
    logic             take_value;
    logic             dup;
    logic             swap;
  } plan_t;

endpackage

// ----- rtl/core/opstk_check.sv -----
module opstk_check
  import opstk_pkg::*;
(
  input  logic [OP_W-1:0]  op,
  input  logic [PTR_W-1:0] ptr,
  output plan_t            plan
);

  logic is_full;
  logic is_empty;
  logic lt_two;

  assign is_full  = (ptr >= PTR_W'(DEPTH));
  assign is_empty = (ptr == '0);
  assign lt_two   = (ptr < PTR_W'(2));

  always_comb begin
    plan            = '0;
    plan.status     = ST_OK;
    plan.ptr_nxt    = ptr;
    case (op)
      OP_PUSH: begin
        if (is_full) begin
          plan.status = ST_FULL;
        end else begin
          plan.push    = 1'b1;
          plan.ptr_nxt = ptr + PTR_W'(1);
        end
      end
      OP_POP: begin
        if (is_empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.read_top   = 1'b1;
          plan.take_value = 1'b1;
          plan.ptr_nxt    = ptr - PTR_W'(1);
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.read_top   = 1'b1;
          plan.take_value = 1'b1;
        end
      end
      OP_DUP: begin
        // full wins over empty
        if (is_full) begin
          plan.status = ST_FULL;
        end else if (is_empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.read_top = 1'b1;
          plan.dup      = 1'b1;
          plan.ptr_nxt  = ptr + PTR_W'(1);
        end
      end
      OP_SWAP: begin
        if (lt_two) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.read_top = 1'b1;
          plan.swap     = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (is_empty) begin
          plan.status = ST_EMPTY;
        end else begin
          plan.ptr_nxt = '0;
        end
      end
      default: begin
        plan.status = ST_OK;
      end
    endcase
  end

endmodule

// ----- rtl/core/operand_stack_with_dup_swap.sv -----
// LIFO stack of 64 64-bit words with push, pop, peek, dup, swap and clear.
// Each input transfer gives exactly one output transfer carrying the popped
// or peeked word, a status (ok, full, empty; too few is empty) and the depth
// after the operation; failed operations leave the stack untouched. Entries
// live in a single-port-write, single-port-read memory with registered read
// data, and every operation is sequenced over that one port pair: push writes,
// clear only moves the pointer, pop and peek read the top, dup reads the top
// and writes the copy, swap reads twice then writes twice. The result sits in
// an output register, so the next operation is taken as soon as the sequencer
// is back to idle, even while the previous result still waits on out_tready.
module operand_stack_with_dup_swap
  import opstk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // operation[2:0], push_value[66:3], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // result_value[63:0], status[65:64],
                                            // depth_after[72:66], zero pad
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUP   = 3'd1;
  localparam logic [2:0] S_SW_RD = 3'd2;
  localparam logic [2:0] S_SW_WA = 3'd3;
  localparam logic [2:0] S_SW_WB = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [PTR_W-1:0]      base_r;
  logic [WORD_W-1:0]     hold_r;
  plan_t                 plan_r;
  plan_t                 plan;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [WORD_W-1:0]     mem [DEPTH];
  logic [WORD_W-1:0]     rd_data_r;

  logic [OP_W-1:0]       in_op;
  logic [WORD_W-1:0]     in_word;
  logic                  in_fire;
  logic                  out_load;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [PTR_W-1:0]      ptr_m1;
  logic [PTR_W-1:0]      base_m1;
  logic [PTR_W-1:0]      base_m2;
  logic [WORD_W-1:0]     res_value;

  assign in_op   = in_tdata[OP_W-1:0];
  assign in_word = in_tdata[OP_W +: WORD_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign ptr_m1  = ptr_r - PTR_W'(1);
  assign base_m1 = base_r - PTR_W'(1);
  assign base_m2 = base_r - PTR_W'(2);

  opstk_check u_check (
    .op   (in_op),
    .ptr  (ptr_r),
    .plan (plan)
  );

  // one read and one write port, sequenced per operation
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_m1[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr_r[ADDR_W-1:0];
    wr_data = in_word;
    case (state_r)
      S_IDLE: begin
        rd_en = in_fire && plan.read_top;
        wr_en = in_fire && plan.push;
      end
      S_DUP: begin
        wr_en   = 1'b1;
        wr_addr = base_r[ADDR_W-1:0];
        wr_data = rd_data_r;
      end
      S_SW_RD: begin
        rd_en   = 1'b1;
        rd_addr = base_m2[ADDR_W-1:0];
      end
      S_SW_WA: begin
        wr_en   = 1'b1;
        wr_addr = base_m1[ADDR_W-1:0];
        wr_data = rd_data_r;
      end
      S_SW_WB: begin
        wr_en   = 1'b1;
        wr_addr = base_m2[ADDR_W-1:0];
        wr_data = hold_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ptr_nxt = plan.ptr_nxt;
          if (plan.dup) begin
            state_nxt = S_DUP;
          end else if (plan.swap) begin
            state_nxt = S_SW_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DUP:   state_nxt = S_DONE;
      S_SW_RD: state_nxt = S_SW_WA;
      S_SW_WA: state_nxt = S_SW_WB;
      S_SW_WB: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res_value = plan_r.take_value ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      plan_r <= plan;
      base_r <= ptr_r;
    end
    // top word comes back while the second read is issued
    if (state_r == S_SW_RD) begin
      hold_r <= rd_data_r;
    end
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W - WORD_W - ST_W - DEP_W)'(0),
                     DEP_W'(ptr_r), plan_r.status, res_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(DEPTH))
    else $error("stack pointer beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer idle right after a transfer");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && plan_r.status == ST_FULL) |-> (ptr_r == PTR_W'(DEPTH)))
    else $error("overflow reported below full depth");

  a_no_hold_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost or changed");

endmodule

// ----- bench/operand_stack_with_dup_swap_tb.sv -----
`timescale 1ns / 1ps

module operand_stack_with_dup_swap_tb;
  import opstk_pkg::*;

  // codes 6 and 7 are not operations; the stack just reports its depth
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam int RANDOM_OPS = 1950;
  localparam int N_DIRECTED = 22;

  typedef struct {
    logic [WORD_W-1:0] value;
    logic [ST_W-1:0]   status;
    logic [DEP_W-1:0]  depth;
  } stack_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] word;
    bit                fixed;
    logic [WORD_W-1:0] value;
    logic [ST_W-1:0]   status;
    logic [DEP_W-1:0]  depth;
  } stack_step_t;

  typedef enum {FILL_RUN, MIXED_RUN, DRAIN_RUN} op_mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [WORD_W-1:0] stack_mirror [DEPTH];
  int                mirror_depth;
  stack_result_t     results_due [$];
  stack_step_t       directed_steps [N_DIRECTED];

  int errors;
  int ops_sent;
  int results_seen;
  int overflows;
  int underflows;
  int peak_depth;

  operand_stack_with_dup_swap dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic stack_result_t apply_stack_op(logic [OP_W-1:0] op,
                                                   logic [WORD_W-1:0] word);
    stack_result_t r;
    logic [WORD_W-1:0] held;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (mirror_depth >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mirror[mirror_depth] = word;
          mirror_depth++;
        end
      end
      OP_POP: begin
        if (mirror_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = stack_mirror[mirror_depth-1];
          mirror_depth--;
        end
      end
      OP_PEEK: begin
        if (mirror_depth == 0) r.status = ST_EMPTY;
        else r.value = stack_mirror[mirror_depth-1];
      end
      OP_DUP: begin
        // full wins over empty
        if (mirror_depth >= DEPTH) begin
          r.status = ST_FULL;
        end else if (mirror_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_mirror[mirror_depth] = stack_mirror[mirror_depth-1];
          mirror_depth++;
        end
      end
      OP_SWAP: begin
        if (mirror_depth < 2) begin
          r.status = ST_EMPTY;
        end else begin
          held = stack_mirror[mirror_depth-1];
          stack_mirror[mirror_depth-1] = stack_mirror[mirror_depth-2];
          stack_mirror[mirror_depth-2] = held;
        end
      end
      OP_CLEAR: begin
        if (mirror_depth == 0) r.status = ST_EMPTY;
        else mirror_depth = 0;
      end
      default: begin
      end
    endcase
    r.depth = DEP_W'(mirror_depth);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] draw_word();
    int k;
    k = $urandom_range(0, WORD_W-1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2: return {{(WORD_W-1){1'b0}}, 1'b1} << k;
      3: return ~({{(WORD_W-1){1'b0}}, 1'b1} << k);
      4: return WORD_W'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [OP_W-1:0] draw_op(op_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      FILL_RUN: begin
        if (r < 70) return OP_PUSH;
        if (r < 80) return OP_DUP;
        if (r < 86) return OP_PEEK;
        if (r < 92) return OP_SWAP;
        if (r < 97) return OP_POP;
        return (r < 98) ? OP_RSVD6 : OP_RSVD7;
      end
      DRAIN_RUN: begin
        if (r < 65) return OP_POP;
        if (r < 75) return OP_PEEK;
        if (r < 83) return OP_SWAP;
        if (r < 88) return OP_PUSH;
        if (r < 92) return OP_DUP;
        if (r < 96) return OP_CLEAR;
        return (r < 98) ? OP_RSVD6 : OP_RSVD7;
      end
      default: begin
        if (r < 27) return OP_PUSH;
        if (r < 47) return OP_POP;
        if (r < 59) return OP_PEEK;
        if (r < 72) return OP_DUP;
        if (r < 88) return OP_SWAP;
        if (r < 91) return OP_CLEAR;
        return (r < 96) ? OP_RSVD6 : OP_RSVD7;
      end
    endcase
  endfunction

  // one input transfer; the expectation is queued at the accepting edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                         input bit fixed, input stack_result_t typed);
    int gap;
    stack_result_t predicted;
    gap = ((ops_sent / 90) % 3 == 2) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-WORD_W-OP_W){1'b0}}, word, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_stack_op(op, word);
    results_due.push_back(fixed ? typed : predicted);
    ops_sent++;
    if (predicted.status == ST_FULL) overflows++;
    if (predicted.status == ST_EMPTY) underflows++;
    if (mirror_depth > peak_depth) peak_depth = mirror_depth;
  endtask

  // receiver: random stall before each transfer, with calm stretches
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ((results_seen / 75) % 3 == 1) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    stack_result_t want;
    logic [WORD_W-1:0] got_value;
    logic [ST_W-1:0]   got_status;
    logic [DEP_W-1:0]  got_depth;
    if (rst_n && out_tvalid && out_tready) begin
      got_value  = out_tdata[WORD_W-1:0];
      got_status = out_tdata[WORD_W+ST_W-1:WORD_W];
      got_depth  = out_tdata[WORD_W+ST_W+DEP_W-1:WORD_W+ST_W];
      results_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result transfer, value %h status %0d depth %0d",
                 $time, got_value, got_status, got_depth);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got_value !== want.value) begin
          $display("%0t: value mismatch, expected %h actual %h",
                   $time, want.value, got_value);
          errors++;
        end
        if (got_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.status, got_status);
          errors++;
        end
        if (got_depth !== want.depth) begin
          $display("%0t: depth mismatch, expected %0d actual %0d",
                   $time, want.depth, got_depth);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[operand_stack_with_dup_swap] ERROR");
    $finish;
  end

  initial begin
    stack_result_t typed;
    op_mix_t mix;
    int run_left;
    int run_idx;
    errors       = 0;
    ops_sent     = 0;
    results_seen = 0;
    overflows    = 0;
    underflows   = 0;
    peak_depth   = 0;
    mirror_depth = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;

    directed_steps = '{
      '{OP_POP,   '0,       1'b1, '0,       ST_EMPTY, 7'd0},
      '{OP_PEEK,  ALL_ONES, 1'b1, '0,       ST_EMPTY, 7'd0},
      '{OP_DUP,   ALL_ONES, 1'b1, '0,       ST_EMPTY, 7'd0},
      '{OP_SWAP,  '0,       1'b1, '0,       ST_EMPTY, 7'd0},
      '{OP_CLEAR, '0,       1'b1, '0,       ST_EMPTY, 7'd0},
      '{OP_RSVD6, ALL_ONES, 1'b1, '0,       ST_OK,    7'd0},
      '{OP_PUSH,  ALL_ONES, 1'b1, '0,       ST_OK,    7'd1},
      '{OP_SWAP,  '0,       1'b1, '0,       ST_EMPTY, 7'd1},
      '{OP_PEEK,  '0,       1'b1, ALL_ONES, ST_OK,    7'd1},
      '{OP_PUSH,  '0,       1'b1, '0,       ST_OK,    7'd2},
      '{OP_SWAP,  '0,       1'b1, '0,       ST_OK,    7'd2},
      '{OP_POP,   '0,       1'b1, ALL_ONES, ST_OK,    7'd1},
      '{OP_POP,   ALL_ONES, 1'b1, '0,       ST_OK,    7'd0},
      '{OP_PUSH,  64'h8000_0000_0000_0001, 1'b0, '0, ST_OK, 7'd0},
      '{OP_DUP,   '0,                      1'b0, '0, ST_OK, 7'd0},
      '{OP_PUSH,  64'h5555_5555_5555_5555, 1'b0, '0, ST_OK, 7'd0},
      '{OP_RSVD7, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, ST_OK, 7'd0},
      '{OP_SWAP,  '0,                      1'b0, '0, ST_OK, 7'd0},
      '{OP_POP,   '0,                      1'b0, '0, ST_OK, 7'd0},
      '{OP_PEEK,  '0,                      1'b0, '0, ST_OK, 7'd0},
      '{OP_CLEAR, '0,                      1'b0, '0, ST_OK, 7'd0},
      '{OP_PEEK,  '0,       1'b1, '0,       ST_EMPTY, 7'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      typed.value  = directed_steps[i].value;
      typed.status = directed_steps[i].status;
      typed.depth  = directed_steps[i].depth;
      send_op(directed_steps[i].op, directed_steps[i].word, directed_steps[i].fixed, typed);
    end

    // runs alternate fill / mixed / drain / mixed so full and empty are hit often
    typed    = '{default: '0};
    run_idx  = 0;
    run_left = 0;
    mix      = FILL_RUN;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (run_left == 0) begin
        case (run_idx % 4)
          0: mix = FILL_RUN;
          2: mix = DRAIN_RUN;
          default: mix = MIXED_RUN;
        endcase
        run_left = $urandom_range(150, 220);
        run_idx++;
      end
      run_left--;
      send_op(draw_op(mix), draw_word(), 1'b0, typed);
    end
    in_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d stack operations, %0d results checked, peak depth %0d",
             ops_sent, results_seen, peak_depth);
    $display("overflow results %0d, underflow results %0d, mismatches %0d",
             overflows, underflows, errors);
    if (errors == 0) begin
      $display("[operand_stack_with_dup_swap] OK");
    end else begin
      $display("[operand_stack_with_dup_swap] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/opstk_pkg.sv
rtl/core/opstk_check.sv
rtl/core/operand_stack_with_dup_swap.sv
bench/operand_stack_with_dup_swap_tb.sv
